### rtl/y86e_pkg.sv
// y86e_pkg: request and result types, opcode, alu function and condition codes
// for the y86 execute stage. no dependencies.
package y86e_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CodeW = 4;

	typedef logic [CodeW-1:0] code_t;
	typedef logic signed [WordW-1:0] word_t;

	// instruction codes
	localparam code_t OP_NOP    = 4'd0;
	localparam code_t OP_HALT   = 4'd1;
	localparam code_t OP_RRMOVL = 4'd2;
	localparam code_t OP_IRMOVL = 4'd3;
	localparam code_t OP_RMMOVL = 4'd4;
	localparam code_t OP_MRMOVL = 4'd5;
	localparam code_t OP_OPL    = 4'd6;
	localparam code_t OP_JXX    = 4'd7;
	localparam code_t OP_CALL   = 4'd8;
	localparam code_t OP_RET    = 4'd9;
	localparam code_t OP_PUSHL  = 4'd10;
	localparam code_t OP_POPL   = 4'd11;
	localparam code_t OP_IADDL  = 4'd12;
	localparam code_t OP_LEAVE  = 4'd13;

	// alu functions for opl
	localparam code_t ALU_ADD = 4'd0;
	localparam code_t ALU_SUB = 4'd1;
	localparam code_t ALU_AND = 4'd2;
	localparam code_t ALU_XOR = 4'd3;

	// jump conditions
	localparam code_t CND_JMP = 4'd0;
	localparam code_t CND_LE  = 4'd1;
	localparam code_t CND_L   = 4'd2;
	localparam code_t CND_E   = 4'd3;
	localparam code_t CND_NE  = 4'd4;
	localparam code_t CND_GE  = 4'd5;
	localparam code_t CND_G   = 4'd6;

	localparam word_t STACK_STEP = 32'sd4;

	typedef struct packed {
		code_t opcode;
		code_t func_code;
		word_t operand_a;
		word_t operand_b;
		word_t constant_word;
	} instr_t;

	typedef struct packed {
		word_t exec_result;
		logic  branch_taken;
		logic  zero_flag;
		logic  sign_flag;
		logic  overflow_flag;
	} result_t;

endpackage

### rtl/y86e_stream_if.sv
// y86e_stream_if: valid/ready channel carrying one payload word per request.
// payload type is set by the instance; no package dependency.
interface y86e_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/y86_execute_alu_condition_codes.sv
// y86 execute stage: takes one request per cycle on instr and returns one result per
// request on result, in order. an accepted request passes through
// an input register, then the alu, flag logic and branch decision, then the result
// register. the zero, sign and overflow flags are updated when an opl or iaddl request
// moves into the result register, so a following jxx sees them with no bubble. the
// sustained rate is one request per clock, set by the single alu pass between the two
// registers; a stall on result backs up into instr through the ready chain.
// uses y86e_pkg and y86e_stream_if.
module y86_execute_alu_condition_codes
	import y86e_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	y86e_stream_if.sink          instr,
	y86e_stream_if.source        result
);

	logic   valid_s1;
	instr_t instr_s1;
	logic   valid_s2;
	result_t result_s2;
	logic   zero_q, sign_q, ovf_q;

	logic advance_s1;
	logic load_s1;

	assign advance_s1  = valid_s1 && (!valid_s2 || result.ready);
	assign instr.ready = !valid_s1 || advance_s1;
	assign load_s1     = instr.valid && instr.ready;

	// alu and condition logic on the registered request
	word_t sel_a, addend, alu_sum, mem_sum, stack_dec, stack_inc, exec_res;
	code_t alu_fn;
	logic  is_arith, upd_flags, branch, lt;
	logic  zero_d, sign_d, ovf_d;

	always_comb begin
		if (instr_s1.opcode == OP_OPL) begin
			sel_a  = instr_s1.operand_a;
			alu_fn = instr_s1.func_code;
		end else begin
			sel_a  = instr_s1.constant_word;
			alu_fn = ALU_ADD;
		end
		is_arith  = (alu_fn == ALU_ADD) || (alu_fn == ALU_SUB);
		addend    = (alu_fn == ALU_SUB) ? -sel_a : sel_a;
		alu_sum   = addend + instr_s1.operand_b;
		mem_sum   = instr_s1.constant_word + instr_s1.operand_b;
		stack_dec = instr_s1.operand_b - STACK_STEP;
		stack_inc = instr_s1.operand_b + STACK_STEP;
		lt        = sign_q ^ ovf_q;
		exec_res  = '0;
		branch    = 1'b0;
		upd_flags = 1'b0;

		unique case (instr_s1.opcode) inside
			OP_RRMOVL:                    exec_res = instr_s1.operand_a;
			OP_IRMOVL:                    exec_res = instr_s1.constant_word;
			OP_RMMOVL, OP_MRMOVL:         exec_res = mem_sum;
			OP_CALL, OP_PUSHL:            exec_res = stack_dec;
			OP_RET, OP_POPL, OP_LEAVE:    exec_res = stack_inc;
			OP_OPL, OP_IADDL: begin
				upd_flags = 1'b1;
				case (alu_fn) inside
					ALU_ADD, ALU_SUB: exec_res = alu_sum;
					ALU_AND:          exec_res = sel_a & instr_s1.operand_b;
					ALU_XOR:          exec_res = sel_a ^ instr_s1.operand_b;
					default:          exec_res = '0;
				endcase
			end
			OP_JXX: begin
				case (instr_s1.func_code)
					CND_JMP: branch = 1'b1;
					CND_LE:  branch = lt | zero_q;
					CND_L:   branch = lt;
					CND_E:   branch = zero_q;
					CND_NE:  branch = !zero_q;
					CND_GE:  branch = !lt;
					CND_G:   branch = !lt && !zero_q;
					default: branch = 1'b0;
				endcase
			end
			default: exec_res = '0;
		endcase

		// overflow uses the negated addend for subtract; positive means nonzero and sign clear
		zero_d = (exec_res == '0);
		sign_d = exec_res[WordW-1];
		ovf_d  = is_arith && (
			((addend != '0) && !addend[WordW-1] &&
			 (instr_s1.operand_b != '0) && !instr_s1.operand_b[WordW-1] &&
			 ((exec_res == '0) || exec_res[WordW-1])) ||
			(addend[WordW-1] && instr_s1.operand_b[WordW-1] && !exec_res[WordW-1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			zero_q   <= 1'b0;
			sign_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			if (instr.ready) begin
				valid_s1 <= instr.valid;
			end
			if (advance_s1) begin
				valid_s2 <= 1'b1;
				if (upd_flags) begin
					zero_q <= zero_d;
					sign_q <= sign_d;
					ovf_q  <= ovf_d;
				end
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			instr_s1 <= instr.payload;
		end
		if (advance_s1) begin
			result_s2.exec_result   <= exec_res;
			result_s2.branch_taken  <= branch;
			result_s2.zero_flag     <= upd_flags ? zero_d : zero_q;
			result_s2.sign_flag     <= upd_flags ? sign_d : sign_q;
			result_s2.overflow_flag <= upd_flags ? ovf_d : ovf_q;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = result_s2;

`ifndef SYNTHESIS
	// flags move only when an opl or iaddl request leaves the first stage
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance_s1 && upd_flags) |=> $stable({zero_q, sign_q, ovf_q}))
		else $error("condition flags changed without a flag-setting request");

	// a pending result reports the flags as they stand in the flag registers
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.payload.zero_flag == zero_q &&
			result.payload.sign_flag == sign_q &&
			result.payload.overflow_flag == ovf_q))
		else $error("result flags disagree with flag registers");

	// a taken branch never carries an alu value
	a_branch_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.branch_taken) |-> (result.payload.exec_result == '0))
		else $error("taken branch with nonzero result");

	// zero and sign flags are never set together
	a_zero_sign: assert property (@(posedge clk) disable iff (!arst_n)
		!(zero_q && sign_q))
		else $error("zero and sign flags both set");
`endif

endmodule

### tb/y86_execute_alu_condition_codes_tb.sv
// testbench for y86_execute_alu_condition_codes: directed and random requests
// checked in order against an in-bench predictor of alu result, branch and flags.
// depends on y86e_pkg, y86e_stream_if and the execute stage rtl.
module y86_execute_alu_condition_codes_tb;
	import y86e_pkg::*;

	localparam word_t WMAX = 32'sh7fff_ffff;
	localparam word_t WMIN = 32'sh8000_0000;
	// codes with no meaning in the isa
	localparam code_t OP_SPARE_LO = 4'he;
	localparam code_t OP_SPARE_HI = 4'hf;
	localparam code_t FC_SPARE_LO = 4'h7;
	localparam code_t FC_SPARE_HI = 4'hf;
	// function field left clear where the opcode ignores it
	localparam code_t FC_NONE = 4'h0;

	localparam int unsigned ITEM_TARGET = 1750;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned HOLD_AT = 500;
	localparam int unsigned HOLD_LEN = 150;

	logic clk;
	logic arst_n = 1'b0;

	logic   req_valid = 1'b0;
	instr_t req_word = '0;
	logic   res_ready = 1'b0;

	y86e_stream_if #(.payload_t(instr_t)) instr_ch ();
	y86e_stream_if #(.payload_t(result_t)) result_ch ();

	assign instr_ch.valid = req_valid;
	assign instr_ch.payload = req_word;
	assign result_ch.ready = res_ready;

	y86_execute_alu_condition_codes dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_ch),
		.result(result_ch)
	);

	instr_t  pending_instrs[$];
	result_t expected_results[$];

	// predictor copy of the condition codes
	logic cc_zero = 1'b0;
	logic cc_sign = 1'b0;
	logic cc_over = 1'b0;

	int unsigned total_items = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned hold_left = 0;
	int unsigned stall_cycles = 0;
	int unsigned fail_count = 0;
	logic [1:0]  phase = 2'd0;
	result_t     got_exp;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t predict_execute(instr_t req);
		result_t r;
		word_t   a;
		word_t   res;
		code_t   f;
		logic    arith;
		logic    br;
		logic    lt;
		res = '0;
		br = 1'b0;
		case (req.opcode) inside
			OP_RRMOVL: res = req.operand_a;
			OP_IRMOVL: res = req.constant_word;
			OP_RMMOVL, OP_MRMOVL: res = req.constant_word + req.operand_b;
			OP_CALL, OP_PUSHL: res = req.operand_b - STACK_STEP;
			OP_RET, OP_POPL, OP_LEAVE: res = req.operand_b + STACK_STEP;
			OP_JXX: begin
				lt = cc_sign ^ cc_over;
				case (req.func_code)
					CND_JMP: br = 1'b1;
					CND_LE:  br = lt | cc_zero;
					CND_L:   br = lt;
					CND_E:   br = cc_zero;
					CND_NE:  br = ~cc_zero;
					CND_GE:  br = ~lt;
					CND_G:   br = ~lt & ~cc_zero;
					default: br = 1'b0;
				endcase
			end
			OP_OPL, OP_IADDL: begin
				f = (req.opcode == OP_OPL) ? req.func_code : ALU_ADD;
				a = (req.opcode == OP_OPL) ? req.operand_a : req.constant_word;
				arith = (f == ALU_ADD) || (f == ALU_SUB);
				// negating the most negative value wraps to itself
				if (f == ALU_SUB)
					a = -a;
				if (arith)
					res = a + req.operand_b;
				else if (f == ALU_AND)
					res = a & req.operand_b;
				else if (f == ALU_XOR)
					res = a ^ req.operand_b;
				else
					res = '0;
				cc_zero = (res == 0);
				cc_sign = res[WordW-1];
				cc_over = arith && ((a > 0 && req.operand_b > 0 && !(res > 0)) ||
					(a < 0 && req.operand_b < 0 && !(res < 0)));
			end
			default: ;
		endcase
		r.exec_result = res;
		r.branch_taken = br;
		r.zero_flag = cc_zero;
		r.sign_flag = cc_sign;
		r.overflow_flag = cc_over;
		return r;
	endfunction

	function automatic instr_t make_instr(code_t op, code_t fc, word_t va, word_t vb, word_t vc);
		instr_t i;
		i.opcode = op;
		i.func_code = fc;
		i.operand_a = va;
		i.operand_b = vb;
		i.constant_word = vc;
		return i;
	endfunction

	function automatic word_t pick_operand();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20) begin
			case ($urandom_range(4))
				0: return WMAX;
				1: return WMIN;
				2: return '0;
				3: return -32'sd1;
				default: return 32'sd1;
			endcase
		end
		if (r < 45)
			return word_t'($signed($urandom_range(16)) - 8);
		return word_t'($urandom);
	endfunction

	task automatic check_field(input string name, input logic [WordW-1:0] exp_v,
		input logic [WordW-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_word <= '0;
			phase <= 2'd0;
		end else begin
			if (req_valid && instr_ch.ready) begin
				expected_results.push_back(predict_execute(req_word));
				void'(pending_instrs.pop_front());
				n_sent++;
			end
			if (!req_valid || instr_ch.ready) begin
				if (pending_instrs.size() > 0 &&
					$urandom_range(99) >= (phase == 2'd0 ? 33 : phase == 2'd1 ? 64 : 0)) begin
					req_valid <= 1'b1;
					req_word <= pending_instrs[0];
				end else begin
					req_valid <= 1'b0;
				end
			end
			phase <= (n_sent < total_items / 3) ? 2'd0 :
				(n_sent < 2 * total_items / 3) ? 2'd1 : 2'd2;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (result_ch.valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request pending: %h", result_ch.payload);
					fail_count++;
				end else begin
					got_exp = expected_results.pop_front();
					check_field("exec_result", got_exp.exec_result,
						result_ch.payload.exec_result);
					check_field("branch_taken", WordW'(got_exp.branch_taken),
						WordW'(result_ch.payload.branch_taken));
					check_field("zero_flag", WordW'(got_exp.zero_flag),
						WordW'(result_ch.payload.zero_flag));
					check_field("sign_flag", WordW'(got_exp.sign_flag),
						WordW'(result_ch.payload.sign_flag));
					check_field("overflow_flag", WordW'(got_exp.overflow_flag),
						WordW'(result_ch.payload.overflow_flag));
				end
				n_checked++;
				// long hold-off so the stage fills and backs up into instr
				if (n_checked == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= $urandom_range(99) >=
					(phase == 2'd0 ? 64 : phase == 2'd1 ? 33 : 0);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((req_valid && instr_ch.ready) || (result_ch.valid && res_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int unsigned r;
		code_t       op;
		code_t       fc;
		// flags at reset, then overflow both ways and the jump conditions
		pending_instrs.push_back(make_instr(OP_JXX, CND_G, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_OPL, ALU_ADD, WMAX, 1, 0));
		pending_instrs.push_back(make_instr(OP_JXX, CND_LE, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_JXX, CND_L, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_OPL, ALU_ADD, WMIN, WMIN, 0));
		pending_instrs.push_back(make_instr(OP_JXX, CND_GE, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_OPL, ALU_SUB, WMIN, -32'sd1, 0));
		pending_instrs.push_back(make_instr(OP_OPL, ALU_SUB, WMIN, 0, 0));
		pending_instrs.push_back(make_instr(OP_OPL, ALU_SUB, 32'sd1234, 32'sd1234, 0));
		pending_instrs.push_back(make_instr(OP_JXX, CND_E, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_JXX, CND_NE, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_OPL, ALU_AND, -32'sd1, WMIN, 0));
		pending_instrs.push_back(make_instr(OP_OPL, ALU_XOR, -32'sd1, -32'sd1, 0));
		pending_instrs.push_back(make_instr(OP_OPL, FC_SPARE_HI, WMAX, WMIN, 0));
		pending_instrs.push_back(make_instr(OP_JXX, FC_SPARE_HI, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_IADDL, FC_SPARE_HI, 0, WMAX, WMAX));
		pending_instrs.push_back(make_instr(OP_JXX, CND_JMP, 0, 0, 0));
		// data movement and stack arithmetic, with wrap at the extremes, then nop, halt and spare opcodes
		pending_instrs.push_back(make_instr(OP_RRMOVL, FC_SPARE_HI, WMIN, WMAX, 0));
		pending_instrs.push_back(make_instr(OP_IRMOVL, FC_NONE, 0, 0, WMAX));
		pending_instrs.push_back(make_instr(OP_RMMOVL, FC_NONE, 0, 1, WMAX));
		pending_instrs.push_back(make_instr(OP_MRMOVL, FC_NONE, 0, WMIN, -32'sd1));
		pending_instrs.push_back(make_instr(OP_CALL, FC_NONE, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_PUSHL, FC_NONE, 0, WMIN, 0));
		pending_instrs.push_back(make_instr(OP_RET, FC_NONE, 0, -32'sd4, 0));
		pending_instrs.push_back(make_instr(OP_POPL, FC_NONE, 0, WMAX, 0));
		pending_instrs.push_back(make_instr(OP_LEAVE, FC_NONE, 0, 32'sd100, 0));
		pending_instrs.push_back(make_instr(OP_NOP, FC_NONE, -32'sd1, -32'sd1, -32'sd1));
		pending_instrs.push_back(make_instr(OP_HALT, FC_NONE, 0, 0, 0));
		pending_instrs.push_back(make_instr(OP_SPARE_LO, FC_NONE, WMAX, WMAX, WMAX));
		pending_instrs.push_back(make_instr(OP_SPARE_HI, FC_SPARE_HI, WMIN, WMIN, WMIN));

		// mostly flag update followed by a branch, the rest any opcode
		while (pending_instrs.size() < ITEM_TARGET) begin
			r = $urandom_range(99);
			if (r < 55) begin
				op = ($urandom_range(3) == 0) ? OP_IADDL : OP_OPL;
				fc = ($urandom_range(9) == 0) ? code_t'($urandom_range(15)) :
					code_t'($urandom_range(3));
				pending_instrs.push_back(make_instr(op, fc, pick_operand(), pick_operand(),
					pick_operand()));
				fc = ($urandom_range(9) == 0) ? code_t'($urandom_range(15, FC_SPARE_LO)) :
					code_t'($urandom_range(6));
				pending_instrs.push_back(make_instr(OP_JXX, fc, pick_operand(),
					pick_operand(), pick_operand()));
			end else begin
				pending_instrs.push_back(make_instr(code_t'($urandom_range(15)),
					code_t'($urandom_range(15)), pick_operand(), pick_operand(),
					pick_operand()));
			end
		end
		total_items = pending_instrs.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (!(pending_instrs.size() == 0 && !req_valid && expected_results.size() == 0) &&
			stall_cycles < STALL_LIMIT)
			@(negedge clk);

		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			if (fail_count == 0 && expected_results.size() == 0)
				$display("RESULT: OK");
			else
				$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

### files.f
rtl/y86e_pkg.sv
rtl/y86e_stream_if.sv
rtl/y86_execute_alu_condition_codes.sv
tb/y86_execute_alu_condition_codes_tb.sv
